[rtl/ffpa_pkg.sv]
// Shared constants, codes and types for the first-fit page allocator.
package ffpa_pkg;

   localparam int DEF_MAX_EXTENTS = 64;
   localparam int DEF_PAGE_BITS   = 20;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_NOFIT = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;
   localparam logic [1:0] ST_ZERO  = 2'd3;

   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   localparam logic REG_REGION_BASE  = 1'b0;
   localparam logic REG_REGION_PAGES = 1'b1;

   typedef struct packed {
      logic load;
      logic ins;
   } cell_ctl_type;

endpackage

[rtl/ffpa_cell.sv]
// One extent slot of the chain: holds an extent and passes scan and shift tokens.
module ffpa_cell
   import ffpa_pkg::*;
#(
   parameter int PAGE_BITS = DEF_PAGE_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cell_ctl_type         ctl,
   input  logic [PAGE_BITS:0]   n,
   input  logic [PAGE_BITS-1:0] base,
   input  logic                 load_valid,
   input  logic [PAGE_BITS-1:0] load_start,
   input  logic [PAGE_BITS:0]   load_len,
   input  logic                 l_valid,
   input  logic [PAGE_BITS-1:0] l_start,
   input  logic [PAGE_BITS:0]   l_len,
   input  logic                 l_cond,
   input  logic                 l_scan_pass,
   input  logic                 l_shift_pass,
   input  logic                 r_valid,
   input  logic [PAGE_BITS-1:0] r_start,
   input  logic [PAGE_BITS:0]   r_len,
   output logic                 valid_o,
   output logic [PAGE_BITS-1:0] start_o,
   output logic [PAGE_BITS:0]   len_o,
   output logic                 cond_o,
   output logic                 scan_pass_o,
   output logic                 shift_pass_o,
   output logic                 tok_o,
   output logic                 hit_o,
   output logic                 exact_o,
   output logic [PAGE_BITS-1:0] hit_start_o
);

   logic                 valid_ff, valid_in;
   logic [PAGE_BITS-1:0] start_ff, start_in;
   logic [PAGE_BITS:0]   len_ff, len_in;
   logic                 scan_ff, shift_ff;
   logic                 hit, exact;
   logic [PAGE_BITS:0]   sum;

   // carry the insert point down the chain: the first cell that qualifies wins
   assign cond_o       = l_cond || !valid_ff || (base < start_ff);
   assign hit          = scan_ff && valid_ff && (len_ff >= n);
   assign exact        = (len_ff == n);
   assign sum          = {1'b0, start_ff} + n;
   assign scan_pass_o  = scan_ff && !hit;
   assign shift_pass_o = shift_ff || (hit && exact);
   assign tok_o        = scan_ff || shift_ff;
   assign hit_o        = hit;
   assign exact_o      = hit && exact;
   assign hit_start_o  = hit ? start_ff : '0;
   assign valid_o      = valid_ff;
   assign start_o      = start_ff;
   assign len_o        = len_ff;

   always_comb begin
      valid_in = valid_ff;
      start_in = start_ff;
      len_in   = len_ff;
      priority if (ctl.load) begin
         valid_in = load_valid;
         start_in = load_start;
         len_in   = load_len;
      end else if (ctl.ins) begin
         if (l_cond) begin
            valid_in = l_valid;
            start_in = l_start;
            len_in   = l_len;
         end else if (cond_o) begin
            valid_in = 1'b1;
            start_in = base;
            len_in   = n;
         end
      end else if (shift_ff || (hit && exact)) begin
         // close the gap: pull the right neighbor in
         valid_in = r_valid;
         start_in = r_start;
         len_in   = r_len;
      end else if (hit) begin
         start_in = sum[PAGE_BITS-1:0];
         len_in   = len_ff - n;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         scan_ff  <= 1'b0;
         shift_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         scan_ff  <= l_scan_pass && !ctl.load;
         shift_ff <= l_shift_pass && !ctl.load;
      end
      start_ff <= start_in;
      len_ff   <= len_in;
   end

endmodule

[rtl/ffpa_ctrl.sv]
// Request sequencer: region registers, free total, extent count and result register.
module ffpa_ctrl
   import ffpa_pkg::*;
#(
   parameter int MAX_EXTENTS = DEF_MAX_EXTENTS,
   parameter int PAGE_BITS   = DEF_PAGE_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_kind,
   input  logic [PAGE_BITS:0]     req_page_count,
   input  logic [PAGE_BITS-1:0]   req_base_page,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [1:0]             rsp_status,
   output logic [PAGE_BITS-1:0]   rsp_page_index,
   output logic [PAGE_BITS:0]     rsp_free_pages,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic                   csr_index,
   input  logic [PAGE_BITS:0]     csr_data,
   input  logic                   any_token,
   input  logic                   hit,
   input  logic                   hit_exact,
   input  logic [PAGE_BITS-1:0]   hit_start,
   output cell_ctl_type           ctl,
   output logic                   inject,
   output logic [PAGE_BITS:0]     n_o,
   output logic [PAGE_BITS-1:0]   base_o,
   output logic                   load_valid,
   output logic [PAGE_BITS-1:0]   load_start,
   output logic [PAGE_BITS:0]     load_len
);

   localparam int CW = PAGE_BITS + 1;
   localparam int NW = $clog2(MAX_EXTENTS + 1);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_INS  = 4'b0010,
      S_SCAN = 4'b0100,
      S_DONE = 4'b1000
   } state_type;

   state_type            state_ff, state_in;
   logic [PAGE_BITS-1:0] base_ff, base_in;
   logic [CW-1:0]        pages_ff, pages_in;
   logic [CW-1:0]        free_ff, free_in;
   logic [NW-1:0]        count_ff, count_in;
   logic [CW-1:0]        n_ff, n_in;
   logic [PAGE_BITS-1:0] rbase_ff, rbase_in;
   logic                 seen_ff, seen_in;
   logic [1:0]           res_status_ff, res_status_in;
   logic [PAGE_BITS-1:0] res_index_ff, res_index_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]           rsp_status_ff, rsp_status_in;
   logic [PAGE_BITS-1:0] rsp_index_ff, rsp_index_in;
   logic [CW-1:0]        rsp_free_ff, rsp_free_in;
   logic                 csr_go, req_go;
   logic [CW-1:0]        room;
   logic [CW:0]          fsum;

   assign csr_ready = (state_ff == S_IDLE);
   assign req_ready = (state_ff == S_IDLE) && !csr_valid;
   assign csr_go    = csr_valid && csr_ready;
   assign req_go    = req_valid && req_ready;

   assign base_in  = (csr_go && csr_index == REG_REGION_BASE) ? csr_data[PAGE_BITS-1:0]
                                                              : base_ff;
   assign pages_in = (csr_go && csr_index == REG_REGION_PAGES) ? csr_data : pages_ff;
   assign room     = {1'b1, {PAGE_BITS{1'b0}}} - {1'b0, base_in};

   assign load_start = base_in;
   assign load_len   = (pages_in > room) ? room : pages_in;
   assign load_valid = (load_len != '0);

   assign n_o    = n_ff;
   assign base_o = rbase_ff;
   assign fsum   = {1'b0, free_ff} + {1'b0, n_ff};

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_page_index = rsp_index_ff;
   assign rsp_free_pages = rsp_free_ff;

   always_comb begin
      state_in      = state_ff;
      free_in       = free_ff;
      count_in      = count_ff;
      n_in          = n_ff;
      rbase_in      = rbase_ff;
      seen_in       = seen_ff;
      res_status_in = res_status_ff;
      res_index_in  = res_index_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_free_in   = rsp_free_ff;
      ctl           = '0;
      inject        = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (csr_go) begin
               ctl.load = 1'b1;
               free_in  = load_len;
               count_in = load_valid ? NW'(1) : '0;
            end else if (req_go) begin
               n_in         = req_page_count;
               rbase_in     = req_base_page;
               seen_in      = 1'b0;
               res_index_in = '0;
               state_in     = S_DONE;
               priority if (req_page_count == '0) begin
                  res_status_in = ST_ZERO;
               end else if (req_kind == KIND_ALLOC) begin
                  if (req_page_count > free_ff) begin
                     res_status_in = ST_NOFIT;
                  end else begin
                     inject   = 1'b1;
                     state_in = S_SCAN;
                  end
               end else if (count_ff >= NW'(MAX_EXTENTS)) begin
                  res_status_in = ST_FULL;
               end else begin
                  state_in = S_INS;
               end
            end
         end
         S_INS: begin
            ctl.ins       = 1'b1;
            count_in      = count_ff + NW'(1);
            free_in       = fsum[CW] ? {CW{1'b1}} : fsum[CW-1:0];
            res_status_in = ST_OK;
            state_in      = S_DONE;
         end
         S_SCAN: begin
            if (hit) begin
               seen_in       = 1'b1;
               res_status_in = ST_OK;
               res_index_in  = hit_start;
               free_in       = free_ff - n_ff;
               if (hit_exact) begin
                  count_in = count_ff - NW'(1);
               end
            end else if (!any_token) begin
               if (!seen_ff) begin
                  res_status_in = ST_NOFIT;
               end
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // wait for the output slot, then publish
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_index_in  = res_index_ff;
               rsp_free_in   = free_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         base_ff      <= '0;
         pages_ff     <= '0;
         free_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         base_ff      <= base_in;
         pages_ff     <= pages_in;
         free_ff      <= free_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff          <= n_in;
      rbase_ff      <= rbase_in;
      seen_ff       <= seen_in;
      res_status_ff <= res_status_in;
      res_index_ff  <= res_index_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_free_ff   <= rsp_free_in;
   end

endmodule

[rtl/first_fit_page_allocator_unit.sv]
// First-fit page allocator: top level with the sequencer and the chain of extent cells.
//
// Requests arrive on req_ (valid/ready): req_kind selects allocate or free,
// req_page_count the page count, req_base_page the start of a freed extent.
// Each request gives exactly one item on rsp_ (valid/ready): status, granted
// start page on a successful allocate, and the free total after the request.
// Region registers are written on csr_ (index 0 base page, 1 page count);
// each write rebuilds the table into a single extent covering the region, clipped to the page space, or none if empty.
// The extent table is a chain of MAX_EXTENTS cells. An allocate sends a scan
// token down the chain one cell per cycle; an exactly used extent is closed
// up by a shift token behind it. An allocate ends when no token is left in
// the chain, so its result waits on the token walk along the chain. A free
// shifts all cells in one step; zero counts, oversize allocates and frees
// into a full table go to the result without touching the chain.
// One request is worked at a time; a finished result waits in the output
// register while the next request is accepted, and a stalled receiver holds
// the next result in the sequencer until the register drains.
// Reset clears the region to empty: no extents and a free total of zero.
module first_fit_page_allocator_unit
   import ffpa_pkg::*;
#(
   parameter int MAX_EXTENTS = DEF_MAX_EXTENTS,
   parameter int PAGE_BITS   = DEF_PAGE_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_kind,
   input  logic [PAGE_BITS:0]   req_page_count,
   input  logic [PAGE_BITS-1:0] req_base_page,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [1:0]           rsp_status,
   output logic [PAGE_BITS-1:0] rsp_page_index,
   output logic [PAGE_BITS:0]   rsp_free_pages,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic                 csr_index,
   input  logic [PAGE_BITS:0]   csr_data
);

   cell_ctl_type         ctl;
   logic                 inject, load_valid;
   logic [PAGE_BITS:0]   n_b, load_len;
   logic [PAGE_BITS-1:0] base_b, load_start;
   logic                 any_token, hit, hit_exact;
   logic [PAGE_BITS-1:0] hit_start;

   logic [MAX_EXTENTS-1:0] c_valid, c_cond, c_scan, c_shift, c_tok, c_hit, c_exact;
   logic [PAGE_BITS-1:0]   c_start [MAX_EXTENTS];
   logic [PAGE_BITS:0]     c_len   [MAX_EXTENTS];
   logic [PAGE_BITS-1:0]   c_hstart[MAX_EXTENTS];

   ffpa_ctrl #(
      .MAX_EXTENTS(MAX_EXTENTS),
      .PAGE_BITS  (PAGE_BITS)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_kind      (req_kind),
      .req_page_count(req_page_count),
      .req_base_page (req_base_page),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_status    (rsp_status),
      .rsp_page_index(rsp_page_index),
      .rsp_free_pages(rsp_free_pages),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .any_token     (any_token),
      .hit           (hit),
      .hit_exact     (hit_exact),
      .hit_start     (hit_start),
      .ctl           (ctl),
      .inject        (inject),
      .n_o           (n_b),
      .base_o        (base_b),
      .load_valid    (load_valid),
      .load_start    (load_start),
      .load_len      (load_len)
   );

   for (genvar i = 0; i < MAX_EXTENTS; i++) begin : g_cell
      logic                 lv, lc, ls, lsh, rv, ldv;
      logic [PAGE_BITS-1:0] lst, rst;
      logic [PAGE_BITS:0]   lln, rln;

      if (i == 0) begin : g_first
         assign lv  = 1'b0;
         assign lc  = 1'b0;
         assign ls  = inject;
         assign lsh = 1'b0;
         assign lst = '0;
         assign lln = '0;
         assign ldv = load_valid;
      end else begin : g_mid
         assign lv  = c_valid[i-1];
         assign lc  = c_cond[i-1];
         assign ls  = c_scan[i-1];
         assign lsh = c_shift[i-1];
         assign lst = c_start[i-1];
         assign lln = c_len[i-1];
         assign ldv = 1'b0;
      end

      if (i == MAX_EXTENTS - 1) begin : g_last
         assign rv  = 1'b0;
         assign rst = '0;
         assign rln = '0;
      end else begin : g_inner
         assign rv  = c_valid[i+1];
         assign rst = c_start[i+1];
         assign rln = c_len[i+1];
      end

      ffpa_cell #(
         .PAGE_BITS(PAGE_BITS)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .n           (n_b),
         .base        (base_b),
         .load_valid  (ldv),
         .load_start  (load_start),
         .load_len    (load_len),
         .l_valid     (lv),
         .l_start     (lst),
         .l_len       (lln),
         .l_cond      (lc),
         .l_scan_pass (ls),
         .l_shift_pass(lsh),
         .r_valid     (rv),
         .r_start     (rst),
         .r_len       (rln),
         .valid_o     (c_valid[i]),
         .start_o     (c_start[i]),
         .len_o       (c_len[i]),
         .cond_o      (c_cond[i]),
         .scan_pass_o (c_scan[i]),
         .shift_pass_o(c_shift[i]),
         .tok_o       (c_tok[i]),
         .hit_o       (c_hit[i]),
         .exact_o     (c_exact[i]),
         .hit_start_o (c_hstart[i])
      );
   end

   assign any_token = |c_tok;
   assign hit       = |c_hit;
   assign hit_exact = |c_exact;

   always_comb begin
      hit_start = '0;
      for (int k = 0; k < MAX_EXTENTS; k++) begin
         hit_start = hit_start | c_hstart[k];
      end
   end

   a_one_token : assert property (@(posedge clock) disable iff (reset) $onehot0(c_tok))
      else $error("more than one token in the extent chain");

   a_one_hit : assert property (@(posedge clock) disable iff (reset) $onehot0(c_hit))
      else $error("more than one cell reports a fit");

   a_load_clears : assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready) |=> !any_token)
      else $error("token survives a region rebuild");

   a_valid_prefix : assert property (@(posedge clock) disable iff (reset)
      !any_token |-> ((c_valid & (c_valid + MAX_EXTENTS'(1))) == '0))
      else $error("occupied cells are not a contiguous prefix");

endmodule
